/* design/grm_pkg.sv */
// ---------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the graph reachability matrix core.
// ---------------------------------------------------------------------------
package grm_pkg;

  localparam int REQ_W  = 3;
  localparam int NODE_W = 6;
  localparam int DEG_W  = 7;
  localparam int CNT_W  = 13;
  localparam int MASK_W = 64;
  localparam int CFG_W  = 7;

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

  localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TEST      = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TRANSPOSE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FWD       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BWD       = 3'd4;

  typedef struct packed {
    logic load_req;
    logic flip;
    logic reach_start;
    logic reach_step;
    logic look;
    logic load_reject;
    logic load_out;
  } grm_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_transpose;
    logic is_reach;
    logic reach_done;
  } grm_sts_t;

endpackage

/* design/grm_in_if.sv */
// ---------------------------------------------------------------------------
// grm_in_if
// Request channel: valid/ready handshake carrying one request word.
// ---------------------------------------------------------------------------
interface grm_in_if;
  logic                         valid;
  logic                         ready;
  logic [grm_pkg::REQ_W-1:0]    req_type;
  logic [grm_pkg::NODE_W-1:0]   from_node;
  logic [grm_pkg::NODE_W-1:0]   to_node;

  modport source (output valid, output req_type, output from_node, output to_node,
                  input ready);
  modport sink (input valid, input req_type, input from_node, input to_node,
                output ready);
endinterface

/* design/grm_out_if.sv */
// ---------------------------------------------------------------------------
// grm_out_if
// Result channel: valid/ready handshake carrying one result word.
// ---------------------------------------------------------------------------
interface grm_out_if;
  logic                         valid;
  logic                         ready;
  logic [grm_pkg::MASK_W-1:0]   reach_mask;
  logic                         edge_present;
  logic [grm_pkg::DEG_W-1:0]    out_degree;
  logic [grm_pkg::DEG_W-1:0]    in_degree;
  logic [grm_pkg::CNT_W-1:0]    edge_total;
  logic                         status;

  modport source (output valid, output reach_mask, output edge_present,
                  output out_degree, output in_degree, output edge_total,
                  output status, input ready);
  modport sink (input valid, input reach_mask, input edge_present,
                input out_degree, input in_degree, input edge_total,
                input status, output ready);
endinterface

/* design/graph_reachability_matrix_core.sv */
// ---------------------------------------------------------------------------
// graph_reachability_matrix_core
// Directed graph held as a bit adjacency matrix with degree counters; serves
// add, test, transpose and forward/backward reachability requests.
// ---------------------------------------------------------------------------
// Sequence: add, test and transpose words are decoded, their rows read and
// looked up, and the result registered; rejected words go from decode to the
// result. A reach query first walks the frontier node by node; each found node
// waits for its row from the registered RAM read.
// Throughput: one word at a time, accepted the cycle after the previous result
// is registered. Reset clears the graph via row valid bits; node_count is 64.
module graph_reachability_matrix_core #(
  parameter int MAX_NODES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  grm_in_if.sink                    in_chan,
  grm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [grm_pkg::CFG_W-1:0] cfg_wdata
);

  grm_pkg::grm_cmd_t cmd;
  grm_pkg::grm_sts_t sts;

  grm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  grm_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_chan.req_type),
    .from_node    (in_chan.from_node),
    .to_node      (in_chan.to_node),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .reach_mask   (out_chan.reach_mask),
    .edge_present (out_chan.edge_present),
    .out_degree   (out_chan.out_degree),
    .in_degree    (out_chan.in_degree),
    .edge_total   (out_chan.edge_total),
    .status       (out_chan.status)
  );

endmodule

/* design/grm_ram.sv */
// ---------------------------------------------------------------------------
// grm_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module grm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/grm_ctrl.sv */
// ---------------------------------------------------------------------------
// grm_ctrl
// Request sequencer: decodes each word and steps the datapath through it.
// ---------------------------------------------------------------------------
module grm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  grm_pkg::grm_sts_t sts,
  output grm_pkg::grm_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_REACH  = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_LOOK   = 7'b0010000,
    ST_DONE   = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.bad) begin
          cmd.load_reject = 1'b1;
          state_nxt       = ST_DONE;
        end else if (sts.is_transpose) begin
          cmd.flip  = 1'b1;
          state_nxt = ST_READ;
        end else if (sts.is_reach) begin
          cmd.reach_start = 1'b1;
          state_nxt       = ST_REACH;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_REACH: begin
        cmd.reach_step = 1'b1;
        if (sts.reach_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/grm_dp.sv */
// ---------------------------------------------------------------------------
// grm_dp
// Datapath: adjacency rows and degrees in two RAMs (graph and its transpose),
// per-row valid bits, the reach frontier and the result registers.
// ---------------------------------------------------------------------------
module grm_dp #(
  parameter int MAX_NODES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  grm_pkg::grm_cmd_t             cmd,
  output grm_pkg::grm_sts_t             sts,
  input  logic [grm_pkg::REQ_W-1:0]     req_type,
  input  logic [grm_pkg::NODE_W-1:0]    from_node,
  input  logic [grm_pkg::NODE_W-1:0]    to_node,
  input  logic                          cfg_we,
  input  logic [grm_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [grm_pkg::MASK_W-1:0]    reach_mask,
  output logic                          edge_present,
  output logic [grm_pkg::DEG_W-1:0]     out_degree,
  output logic [grm_pkg::DEG_W-1:0]     in_degree,
  output logic [grm_pkg::CNT_W-1:0]     edge_total,
  output logic                          status
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int WW = MAX_NODES + grm_pkg::DEG_W;
  localparam logic [grm_pkg::CFG_W-1:0] MAX_CNT = grm_pkg::CFG_W'(MAX_NODES);

  // The set bit with the lowest index, found per group of eight bits.
  function automatic logic [5:0] first_set(input logic [63:0] v);
    logic [7:0] grp_any;
    logic [2:0] g;
    logic [7:0] bits;
    logic [2:0] b;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |v[i*8 +: 8];
    end
    g = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) g = 3'(i);
    end
    bits = v[{g, 3'b000} +: 8];
    b = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (bits[i]) b = 3'(i);
    end
    return {g, b};
  endfunction

  logic [grm_pkg::REQ_W-1:0]  req_r;
  logic [grm_pkg::NODE_W-1:0] from_r, to_r;
  logic [grm_pkg::CFG_W-1:0]  node_cfg_r;
  logic                       tr_r, tr_nxt;
  logic [1:0][MAX_NODES-1:0]  vld_r, vld_nxt;
  logic [1:0]                 rvld_r, rvld_nxt;
  logic [grm_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [MAX_NODES-1:0]       seen_r, seen_nxt;
  logic [MAX_NODES-1:0]       done_r, done_nxt;
  logic                       inflight_r, inflight_nxt;

  logic [grm_pkg::MASK_W-1:0] res_mask_r, out_mask_r;
  logic                       res_present_r, out_present_r;
  logic [grm_pkg::DEG_W-1:0]  res_out_deg_r, out_out_deg_r;
  logic [grm_pkg::DEG_W-1:0]  res_in_deg_r, out_in_deg_r;
  logic [grm_pkg::CNT_W-1:0]  res_total_r, out_total_r;
  logic                       res_status_r, out_status_r;

  logic [1:0]                 we;
  logic [1:0][AW-1:0]         waddr, raddr;
  logic [1:0][WW-1:0]         wdata, rdata, word;

  logic [grm_pkg::CFG_W-1:0]  n_live;
  logic [MAX_NODES-1:0]       live_mask;
  logic                       from_bad, to_bad, is_reach, backward;
  logic                       from_ok, to_ok;
  logic [AW-1:0]              from_a, to_a, pick_a;
  logic [MAX_NODES-1:0]       pend;
  logic                       pend_any;
  logic [5:0]                 pick;
  logic                       reach_phys;
  logic [MAX_NODES-1:0]       reach_row;
  logic [WW-1:0]              word_fwd, word_bwd;
  logic [MAX_NODES-1:0]       fwd_row, bwd_row;
  logic [grm_pkg::DEG_W-1:0]  fwd_deg, bwd_deg;
  logic                       present_old, do_add;

  for (genvar k = 0; k < 2; k++) begin : g_ram
    grm_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_NODES)
    ) u_ram (
      .clk   (clk),
      .we    (we[k]),
      .waddr (waddr[k]),
      .wdata (wdata[k]),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
    assign word[k] = rvld_r[k] ? rdata[k] : '0;
  end

  always_comb begin
    n_live = (node_cfg_r > MAX_CNT) ? MAX_CNT : node_cfg_r;
    for (int i = 0; i < MAX_NODES; i++) begin
      live_mask[i] = i < int'(n_live);
    end
    from_bad = {1'b0, from_r} >= n_live;
    to_bad   = {1'b0, to_r} >= n_live;
    is_reach = req_r inside {grm_pkg::REQ_FWD, grm_pkg::REQ_BWD};
    backward = req_r == grm_pkg::REQ_BWD;

    sts.is_transpose = req_r == grm_pkg::REQ_TRANSPOSE;
    sts.is_reach     = is_reach;
    if (sts.is_transpose) begin
      sts.bad = 1'b0;
    end else if (is_reach) begin
      sts.bad = from_bad;
    end else begin
      sts.bad = from_bad || to_bad;
    end

    from_ok = int'(from_r) < MAX_NODES;
    to_ok   = int'(to_r) < MAX_NODES;
    from_a  = from_r[AW-1:0];
    to_a    = to_r[AW-1:0];

    pend     = seen_r & ~done_r;
    pend_any = |pend;
    pick     = first_set(grm_pkg::MASK_W'(pend));
    pick_a   = pick[AW-1:0];
    sts.reach_done = !pend_any && !inflight_r;

    reach_phys = tr_r ^ backward;
    reach_row  = word[reach_phys][MAX_NODES-1:0];

    word_fwd = word[tr_r];
    word_bwd = word[~tr_r];
    fwd_row  = word_fwd[MAX_NODES-1:0];
    bwd_row  = word_bwd[MAX_NODES-1:0];
    fwd_deg  = word_fwd[WW-1 -: grm_pkg::DEG_W];
    bwd_deg  = word_bwd[WW-1 -: grm_pkg::DEG_W];

    present_old = from_ok && to_ok && fwd_row[to_a];
    do_add      = (req_r == grm_pkg::REQ_ADD) && !present_old;

    for (int k = 0; k < 2; k++) begin
      if (cmd.reach_step) begin
        raddr[k] = pick_a;
      end else begin
        raddr[k] = (1'(k) == tr_r) ? from_a : to_a;
      end
      rvld_nxt[k] = (int'(raddr[k]) < MAX_NODES) && vld_r[k][raddr[k]];
    end

    we              = {2{cmd.look && do_add}};
    waddr           = '0;
    wdata           = '0;
    waddr[tr_r]     = from_a;
    wdata[tr_r]     = {fwd_deg + 7'd1, fwd_row | (MAX_NODES'(1) << to_a)};
    waddr[~tr_r]    = to_a;
    wdata[~tr_r]    = {bwd_deg + 7'd1, bwd_row | (MAX_NODES'(1) << from_a)};

    vld_nxt = vld_r;
    cnt_nxt = cnt_r;
    if (cmd.look && do_add) begin
      vld_nxt[tr_r][from_a] = 1'b1;
      vld_nxt[~tr_r][to_a]  = 1'b1;
      cnt_nxt               = cnt_r + 13'd1;
    end

    tr_nxt = cmd.flip ? ~tr_r : tr_r;

    seen_nxt     = seen_r;
    done_nxt     = done_r;
    inflight_nxt = inflight_r;
    if (cmd.reach_start) begin
      seen_nxt     = MAX_NODES'(1) << from_a;
      done_nxt     = '0;
      inflight_nxt = 1'b0;
    end else if (cmd.reach_step) begin
      if (inflight_r) begin
        seen_nxt = seen_r | (reach_row & live_mask);
      end
      if (pend_any) begin
        done_nxt[pick_a] = 1'b1;
      end
      inflight_nxt = pend_any;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_cfg_r <= grm_pkg::NODE_COUNT_RST;
      tr_r       <= 1'b0;
      vld_r      <= '0;
      cnt_r      <= '0;
      inflight_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_cfg_r <= cfg_wdata;
      end
      tr_r       <= tr_nxt;
      vld_r      <= vld_nxt;
      cnt_r      <= cnt_nxt;
      inflight_r <= inflight_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rvld_r <= rvld_nxt;
    seen_r <= seen_nxt;
    done_r <= done_nxt;
    if (cmd.load_req) begin
      req_r  <= req_type;
      from_r <= from_node;
      to_r   <= to_node;
    end
    if (cmd.look) begin
      res_mask_r    <= is_reach ? grm_pkg::MASK_W'(seen_r) : '0;
      res_present_r <= present_old || do_add;
      res_out_deg_r <= from_ok ? fwd_deg + grm_pkg::DEG_W'(do_add) : '0;
      res_in_deg_r  <= to_ok ? bwd_deg + grm_pkg::DEG_W'(do_add) : '0;
      res_total_r   <= cnt_nxt;
      res_status_r  <= 1'b0;
    end else if (cmd.load_reject) begin
      res_mask_r    <= '0;
      res_present_r <= 1'b0;
      res_out_deg_r <= '0;
      res_in_deg_r  <= '0;
      res_total_r   <= cnt_r;
      res_status_r  <= 1'b1;
    end
    if (cmd.load_out) begin
      out_mask_r    <= res_mask_r;
      out_present_r <= res_present_r;
      out_out_deg_r <= res_out_deg_r;
      out_in_deg_r  <= res_in_deg_r;
      out_total_r   <= res_total_r;
      out_status_r  <= res_status_r;
    end
  end

  assign reach_mask   = out_mask_r;
  assign edge_present = out_present_r;
  assign out_degree   = out_out_deg_r;
  assign in_degree    = out_in_deg_r;
  assign edge_total   = out_total_r;
  assign status       = out_status_r;

endmodule
